// ===== hw/rtl/clds_pkg.sv =====
// Shared types and codes for the circular list deque search block.
package clds_pkg;

    localparam int VAL_W     = 32;
    localparam int CODE_W    = 3;
    localparam int CNT_MAX_W = 7;   // holds an entry count up to the largest supported depth

    typedef enum logic [CODE_W-1:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_BACK  = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_SEARCH     = 3'd4,
        REQ_LIST       = 3'd5
    } req_type_t;

    typedef enum logic [CODE_W-1:0] {
        ST_DONE      = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_FULL      = 3'd2,
        ST_FOUND     = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_LISTED    = 3'd5
    } status_t;

    // Control broadcast to every cell of the chain
    typedef struct packed {
        logic                 shift_r;   // push front: every entry moves one place back
        logic                 shift_l;   // pop front: every entry moves one place forward
        logic                 rotate;    // walk: live entries turn by one, front wraps to tail
        logic                 append;    // push back: cell at the count position loads
        logic [CNT_MAX_W-1:0] count;
        logic [VAL_W-1:0]     value;
    } cell_ctrl_t;

endpackage

// ===== hw/rtl/clds_cell.sv =====
// One storage cell of the deque chain, holding the entry at a fixed position.
module clds_cell #(
    parameter int IDX = 0
) (
    input  logic                      aclk,
    input  clds_pkg::cell_ctrl_t      ctrl,
    input  logic [clds_pkg::VAL_W-1:0] left_data,
    input  logic [clds_pkg::VAL_W-1:0] right_data,
    input  logic [clds_pkg::VAL_W-1:0] head_data,
    output logic [clds_pkg::VAL_W-1:0] data_out
);
    import clds_pkg::*;

    logic [VAL_W-1:0] data_reg;
    logic [VAL_W-1:0] data_next;
    logic             is_tail;
    logic             is_free_slot;

    assign is_tail      = (ctrl.count == CNT_MAX_W'(IDX + 1));
    assign is_free_slot = (ctrl.count == CNT_MAX_W'(IDX));

    always_comb begin
        data_next = data_reg;
        priority if (ctrl.shift_r) begin
            data_next = left_data;
        end else if (ctrl.shift_l) begin
            data_next = right_data;
        end else if (ctrl.rotate) begin
            data_next = is_tail ? head_data : right_data;
        end else if (ctrl.append && is_free_slot) begin
            data_next = ctrl.value;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_out = data_reg;

endmodule

// ===== hw/rtl/circular_list_deque_search.sv =====
// Pushes and pops: the result is registered at the end of the cycle that accepts the item.
// Search: after the accept cycle, the chain turns once past the front comparator, pausing
// while a result waits at the output.
// List: N results, one per cycle while the output is taken; one chain rotation per result.
// An empty-store search or list is answered from its accept cycle. One item is in work at a time.
// Reset (aresetn low, synchronous) empties the deque; entry cells are not cleared.
module circular_list_deque_search #(
    parameter int DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] item_value
    input  logic [2:0]  s_tuser,   // [2:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] out_value
    output logic [2:0]  m_tuser,   // [2:0] status
    output logic        m_tlast
);
    import clds_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WALK = 2'b10
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   walk_reg, walk_next;
    logic [VAL_W-1:0]   key_reg, key_next;
    logic               is_list_reg, is_list_next;
    logic               found_reg, found_next;

    logic               m_tvalid_reg, m_tvalid_next;
    logic [VAL_W-1:0]   m_tdata_reg, m_tdata_next;
    logic [CODE_W-1:0]  m_tuser_reg, m_tuser_next;
    logic               m_tlast_reg, m_tlast_next;

    logic               out_free;
    logic               accept;
    logic               is_full;
    logic               is_empty;
    logic               walk_last;
    logic               hit;
    cell_ctrl_t         ctrl;
    logic [VAL_W-1:0]   cell_data [DEPTH];

    assign out_free  = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE) && out_free;
    assign accept    = s_tvalid && s_tready;
    assign is_full   = (cnt_reg == CNT_W'(DEPTH));
    assign is_empty  = (cnt_reg == '0);
    assign walk_last = (walk_reg == CNT_W'(1));
    assign hit       = (cell_data[0] == key_reg);

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        walk_next     = walk_reg;
        key_next      = key_reg;
        is_list_next  = is_list_reg;
        found_next    = found_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        ctrl          = '0;
        ctrl.count    = CNT_MAX_W'(cnt_reg);
        ctrl.value    = s_tdata;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    m_tdata_next = '0;
                    m_tlast_next = 1'b1;
                    unique case (s_tuser)
                        REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
                            m_tvalid_next = 1'b1;
                            if (is_full) begin
                                m_tuser_next = ST_FULL;
                            end else begin
                                m_tuser_next = ST_DONE;
                                cnt_next     = cnt_reg + CNT_W'(1);
                                ctrl.shift_r = (s_tuser == REQ_PUSH_FRONT);
                                ctrl.append  = (s_tuser == REQ_PUSH_BACK);
                            end
                        end
                        REQ_POP_FRONT, REQ_POP_BACK: begin
                            m_tvalid_next = 1'b1;
                            if (is_empty) begin
                                m_tuser_next = ST_EMPTY;
                            end else begin
                                m_tuser_next = ST_DONE;
                                cnt_next     = cnt_reg - CNT_W'(1);
                                ctrl.shift_l = (s_tuser == REQ_POP_FRONT);
                            end
                        end
                        REQ_SEARCH, REQ_LIST: begin
                            if (is_empty) begin
                                m_tvalid_next = 1'b1;
                                m_tuser_next  = ST_EMPTY;
                            end else begin
                                state_next   = S_WALK;
                                walk_next    = cnt_reg;
                                key_next     = s_tdata;
                                is_list_next = (s_tuser == REQ_LIST);
                                found_next   = 1'b0;
                            end
                        end
                        default: begin
                            // unused request codes are dropped
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (out_free) begin
                    ctrl.rotate = 1'b1;
                    walk_next   = walk_reg - CNT_W'(1);
                    found_next  = found_reg || hit;
                    if (is_list_reg) begin
                        m_tvalid_next = 1'b1;
                        m_tuser_next  = ST_LISTED;
                        m_tdata_next  = cell_data[0];
                        m_tlast_next  = walk_last;
                    end else if (walk_last) begin
                        m_tvalid_next = 1'b1;
                        m_tuser_next  = (found_reg || hit) ? ST_FOUND : ST_NOT_FOUND;
                        m_tdata_next  = key_reg;
                        m_tlast_next  = 1'b1;
                    end
                    if (walk_last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        walk_reg    <= walk_next;
        key_reg     <= key_next;
        is_list_reg <= is_list_next;
        found_reg   <= found_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic [VAL_W-1:0] left_data;
            logic [VAL_W-1:0] right_data;

            if (gi == 0) begin : g_first
                assign left_data = ctrl.value;
            end else begin : g_inner_l
                assign left_data = cell_data[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_end
                assign right_data = cell_data[gi];
            end else begin : g_inner_r
                assign right_data = cell_data[gi+1];
            end

            clds_cell #(
                .IDX(gi)
            ) u_cell (
                .aclk      (aclk),
                .ctrl      (ctrl),
                .left_data (left_data),
                .right_data(right_data),
                .head_data (cell_data[0]),
                .data_out  (cell_data[gi])
            );
        end
    endgenerate

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// ===== hw/rtl/clds_checker.sv =====
// Port-level checks for the deque search block, bound to the top level.
module clds_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);
    import clds_pkg::*;

    // a stalled result item holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result item changed while stalled");

    // only a list run spans several items
    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ST_LISTED) |-> m_tlast)
        else $error("status item without last");

    a_zero_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ((m_tuser == ST_DONE) || (m_tuser == ST_EMPTY) || (m_tuser == ST_FULL))
        |-> (m_tdata == '0))
        else $error("status item carries data");

    // no new request while a list run is still going
    a_list_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_LISTED) && !m_tlast |-> !s_tready)
        else $error("request taken during a list run");

endmodule

bind circular_list_deque_search clds_checker u_clds_checker (.*);

// ===== sim/tb_circular_list_deque_search.sv =====
// Self-checking testbench for the circular list deque search block.
`timescale 1ns / 100ps

module tb_circular_list_deque_search;
    import clds_pkg::*;

    localparam int DEPTH         = 16;
    localparam int RANDOM_ITEMS  = 225;
    localparam int QUIET_FROM    = 190;   // no idling on either side from this item on
    localparam int WATCHDOG_MAX  = 1000;
    localparam int DRAIN_CYCLES  = 40;

    typedef enum int {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIXED
    } phase_mode_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] value;
        logic        last;
    } deque_result_t;

    typedef struct {
        logic [2:0]  req;
        logic [31:0] value;
        bit          typed;      // expected result written into the row
        status_t     status;
        logic [31:0] out_value;
    } stim_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // [31:0] item_value
    logic [2:0]  s_tuser  = '0;   // [2:0] req_type
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [31:0] m_tdata;         // [31:0] out_value
    logic [2:0]  m_tuser;         // [2:0] status
    logic        m_tlast;

    // deque model state
    logic [31:0] deque_store [DEPTH];
    int unsigned deque_front = 0;
    int unsigned deque_count = 0;

    deque_result_t expected_results [$];
    deque_result_t step_results [$];
    stim_row_t     directed_rows [$];

    int errors      = 0;
    int idle_cycles = 0;
    int gap_pct     = 25;
    int stall_pct   = 20;
    bit quiet_tail  = 1'b0;

    circular_list_deque_search #(
        .DEPTH(DEPTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic void add_result(status_t st, logic [31:0] v, logic lst);
        deque_result_t r;
        r.status = st;
        r.value  = v;
        r.last   = lst;
        step_results.push_back(r);
    endfunction

    // Works out the results of one request and updates the deque model
    function automatic void deque_step(logic [2:0] req, logic [31:0] val);
        bit hit;
        step_results.delete();
        hit = 1'b0;
        case (req)
            REQ_PUSH_FRONT: begin
                if (deque_count >= DEPTH) begin
                    add_result(ST_FULL, '0, 1'b1);
                end else begin
                    deque_front = (deque_front + DEPTH - 1) % DEPTH;
                    deque_store[deque_front] = val;
                    deque_count++;
                    add_result(ST_DONE, '0, 1'b1);
                end
            end
            REQ_PUSH_BACK: begin
                if (deque_count >= DEPTH) begin
                    add_result(ST_FULL, '0, 1'b1);
                end else begin
                    deque_store[(deque_front + deque_count) % DEPTH] = val;
                    deque_count++;
                    add_result(ST_DONE, '0, 1'b1);
                end
            end
            REQ_POP_FRONT: begin
                if (deque_count == 0) begin
                    add_result(ST_EMPTY, '0, 1'b1);
                end else begin
                    deque_front = (deque_front + 1) % DEPTH;
                    deque_count--;
                    add_result(ST_DONE, '0, 1'b1);
                end
            end
            REQ_POP_BACK: begin
                if (deque_count == 0) begin
                    add_result(ST_EMPTY, '0, 1'b1);
                end else begin
                    deque_count--;
                    add_result(ST_DONE, '0, 1'b1);
                end
            end
            REQ_SEARCH: begin
                if (deque_count == 0) begin
                    add_result(ST_EMPTY, '0, 1'b1);
                end else begin
                    for (int i = 0; i < deque_count; i++)
                        if (deque_store[(deque_front + i) % DEPTH] == val)
                            hit = 1'b1;
                    add_result(hit ? ST_FOUND : ST_NOT_FOUND, val, 1'b1);
                end
            end
            REQ_LIST: begin
                if (deque_count == 0) begin
                    add_result(ST_EMPTY, '0, 1'b1);
                end else begin
                    for (int i = 0; i < deque_count; i++)
                        add_result(ST_LISTED, deque_store[(deque_front + i) % DEPTH],
                                   (i + 1 == deque_count));
                end
            end
            default: ;   // unused codes give nothing
        endcase
    endfunction

    function automatic void add_row(logic [2:0] req, logic [31:0] value, bit typed = 1'b0,
                                    status_t st = ST_DONE, logic [31:0] ov = '0);
        stim_row_t row;
        row.req       = req;
        row.value     = value;
        row.typed     = typed;
        row.status    = st;
        row.out_value = ov;
        directed_rows.push_back(row);
    endfunction

    function automatic logic [31:0] pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 20) begin
            case ($urandom_range(0, 3))
                0:       return 32'h0000_0000;
                1:       return 32'hFFFF_FFFF;
                2:       return 32'h8000_0000;
                default: return 32'h7FFF_FFFF;
            endcase
        end
        if (roll < 45)
            return 32'($urandom_range(0, 15));   // small pool so searches hit
        return $urandom;
    endfunction

    // Present one item, wait for it to be taken, record what it should cause
    task automatic apply_item(logic [2:0] req, logic [31:0] val, bit typed,
                              status_t st, logic [31:0] ov);
        deque_result_t r;
        s_tuser  <= req;
        s_tdata  <= val;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        deque_step(req, val);
        if (typed) begin
            r.status = st;
            r.value  = ov;
            r.last   = 1'b1;
            expected_results.push_back(r);
        end else begin
            foreach (step_results[i])
                expected_results.push_back(step_results[i]);
        end
        if (!quiet_tail && $urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7))
                @(posedge aclk);
        end
    endtask

    // Result side: back-pressure, checking and activity tracking
    initial begin
        int            stall_left;
        deque_result_t exp_res;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (aresetn && m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result with nothing expected: status %0d out_value %h last %0b",
                           m_tuser, m_tdata, m_tlast);
                    errors++;
                end else begin
                    exp_res = expected_results.pop_front();
                    if (m_tuser !== exp_res.status) begin
                        $error("status: expected %0d, actual %0d", exp_res.status, m_tuser);
                        errors++;
                    end
                    if (m_tdata !== exp_res.value) begin
                        $error("out_value: expected %h, actual %h", exp_res.value, m_tdata);
                        errors++;
                    end
                    if (m_tlast !== exp_res.last) begin
                        $error("last: expected %0b, actual %0b", exp_res.last, m_tlast);
                        errors++;
                    end
                end
            end
            if (stall_left > 0)
                stall_left--;
            else if (!quiet_tail && $urandom_range(0, 99) < stall_pct)
                stall_left = $urandom_range(1, 7);
            m_tready <= (stall_left == 0);
        end
    end

    initial begin
        while (idle_cycles < WATCHDOG_MAX)
            @(posedge aclk);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        phase_mode_t mode;
        int          phase_left;
        int          counted;
        int          roll;
        logic [2:0]  req;
        logic [31:0] val;

        foreach (deque_store[i])
            deque_store[i] = '0;
        phase_left = 0;
        counted    = 0;
        mode       = MODE_MIXED;

        // empty deque first, then fill to the brim, refuse further pushes, search, list and pop
        add_row(REQ_POP_FRONT, 32'h1234_5678, 1'b1, ST_EMPTY, '0);
        add_row(REQ_POP_BACK,  32'hFFFF_FFFF, 1'b1, ST_EMPTY, '0);
        add_row(REQ_SEARCH,    32'h0000_0000, 1'b1, ST_EMPTY, '0);
        add_row(REQ_LIST,      32'h8000_0000, 1'b1, ST_EMPTY, '0);
        add_row(3'd7,          32'hFFFF_FFFF);
        add_row(REQ_PUSH_BACK,  32'h7FFF_FFFF, 1'b1, ST_DONE, '0);
        add_row(REQ_PUSH_FRONT, 32'h8000_0000, 1'b1, ST_DONE, '0);
        add_row(REQ_PUSH_BACK,  32'h0000_0000, 1'b1, ST_DONE, '0);
        add_row(REQ_PUSH_FRONT, 32'hFFFF_FFFF, 1'b1, ST_DONE, '0);
        for (int i = 0; i < DEPTH - 4; i++)
            add_row((i % 2) ? REQ_PUSH_FRONT : REQ_PUSH_BACK, 32'hA5A5_0000 + i);
        add_row(REQ_PUSH_FRONT, 32'h1111_1111, 1'b1, ST_FULL, '0);
        add_row(REQ_PUSH_BACK,  32'h2222_2222, 1'b1, ST_FULL, '0);
        add_row(REQ_SEARCH,     32'h8000_0000, 1'b1, ST_FOUND, 32'h8000_0000);
        add_row(REQ_LIST,       32'h0000_0000);
        add_row(REQ_POP_FRONT,  32'h0000_0000, 1'b1, ST_DONE, '0);
        add_row(REQ_POP_BACK,   32'h0000_0000, 1'b1, ST_DONE, '0);

        repeat (10)
            @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            apply_item(directed_rows[i].req, directed_rows[i].value, directed_rows[i].typed,
                       directed_rows[i].status, directed_rows[i].out_value);

        while (counted < RANDOM_ITEMS) begin
            if (phase_left == 0) begin
                mode       = phase_mode_t'($urandom_range(0, 2));
                phase_left = $urandom_range(16, 40);
                case ($urandom_range(0, 2))
                    0:       gap_pct = 0;
                    1:       gap_pct = 15;
                    default: gap_pct = 40;
                endcase
                case ($urandom_range(0, 2))
                    0:       stall_pct = 0;
                    1:       stall_pct = 10;
                    default: stall_pct = 30;
                endcase
            end
            quiet_tail = (counted >= QUIET_FROM);
            roll = $urandom_range(0, 99);
            val  = pick_value();
            if (roll < 3) begin
                req = 3'($urandom_range(6, 7));
            end else begin
                roll = $urandom_range(0, 99);
                case (mode)
                    MODE_FILL:  req = (roll < 55) ? REQ_PUSH_FRONT : (roll < 70) ? REQ_POP_FRONT :
                                      (roll < 85) ? REQ_SEARCH : REQ_LIST;
                    MODE_DRAIN: req = (roll < 20) ? REQ_PUSH_FRONT : (roll < 70) ? REQ_POP_FRONT :
                                      (roll < 85) ? REQ_SEARCH : REQ_LIST;
                    default:    req = (roll < 35) ? REQ_PUSH_FRONT : (roll < 65) ? REQ_POP_FRONT :
                                      (roll < 85) ? REQ_SEARCH : REQ_LIST;
                endcase
                // pick the end at random for pushes and pops
                if (req == REQ_PUSH_FRONT && $urandom_range(0, 1))
                    req = REQ_PUSH_BACK;
                else if (req == REQ_POP_FRONT && $urandom_range(0, 1))
                    req = REQ_POP_BACK;
                // most searches look for a live entry
                if (req == REQ_SEARCH && deque_count > 0 && $urandom_range(0, 99) < 60)
                    val = deque_store[(deque_front + $urandom_range(0, deque_count - 1)) % DEPTH];
                counted++;
                phase_left--;
            end
            apply_item(req, val, 1'b0, ST_DONE, '0);
        end

        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES)
            @(posedge aclk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
